// ===== hdl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, command codes and the default colour pattern of the
// LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  // item kinds on the request channel
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  // host command codes (ASCII)
  localparam logic [7:0] CMD_FADE    = 8'h63; // 'c'
  localparam logic [7:0] CMD_SET_NOW = 8'h6E; // 'n'
  localparam logic [7:0] CMD_PLAY    = 8'h70; // 'p'
  localparam logic [7:0] CMD_WRITE   = 8'h50; // 'P'
  localparam logic [7:0] CMD_READ    = 8'h52; // 'R'
  localparam logic [7:0] CMD_WDOG    = 8'h44; // 'D'
  localparam logic [7:0] CMD_VERSION = 8'h76; // 'v'
  localparam logic [7:0] CMD_TEST    = 8'h21; // '!'

  // reply constants
  localparam logic [7:0] VERSION_CHAR = 8'h31; // '1'
  localparam logic [7:0] TEST_BYTE_A  = 8'h55;
  localparam logic [7:0] TEST_BYTE_B  = 8'hAA;

  // play flag value selecting power-up mode
  localparam logic [7:0] PLAY_FLAG_POWERUP = 8'd2;

  // configuration register reset values
  localparam logic [15:0] POWERUP_WAIT_RST  = 16'd500;
  localparam logic [7:0]  DURATION_UNIT_RST = 8'd10;
  localparam logic [7:0]  CHECK_PERIOD_RST  = 8'd10;

  // default pattern: 12 entries, repeated for deeper tables
  localparam int DEFAULT_LEN = 12;
  localparam int DEF_IDX_W   = 6;

  typedef enum logic [1:0] {
    CFG_POWERUP_WAIT  = 2'd0,
    CFG_DURATION_UNIT = 2'd1,
    CFG_CHECK_PERIOD  = 2'd2
  } cfg_addr_t;

  typedef enum logic [2:0] {
    ACT_FADE    = 3'd0,
    ACT_SET_NOW = 3'd1,
    ACT_ENTRY   = 3'd2,
    ACT_VERSION = 3'd3,
    ACT_TEST    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PLAY_STOP    = 2'd0,
    PLAY_NORMAL  = 2'd1,
    PLAY_POWERUP = 2'd2
  } play_mode_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
  } entry_t;

  // one result on its way from the control stage to the output stage
  typedef struct packed {
    logic        step;      // pattern step: advances the step deadline
    logic        use_entry; // colour and duration come from the table read
    action_t     action;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
    logic [7:0]  info_a;
    logic [7:0]  info_b;
    logic        info_c;
  } item_t;

  // status from the output stages back to the control stage
  typedef struct packed {
    logic        ready;    // control may accept an item this cycle
    logic        step_en;  // add step_amt to the step deadline
    logic [23:0] step_amt;
  } flow_t;

  // wrap-aware "a is after b"
  function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  // default table contents for an entry index
  function automatic entry_t default_entry(input logic [DEF_IDX_W-1:0] idx);
    logic [DEF_IDX_W-1:0] k;
    entry_t e;
    k = idx;
    if (k >= DEF_IDX_W'(4 * DEFAULT_LEN)) k = k - DEF_IDX_W'(4 * DEFAULT_LEN);
    if (k >= DEF_IDX_W'(2 * DEFAULT_LEN)) k = k - DEF_IDX_W'(2 * DEFAULT_LEN);
    if (k >= DEF_IDX_W'(DEFAULT_LEN))     k = k - DEF_IDX_W'(DEFAULT_LEN);
    unique case (k[3:0])
      4'd0:    e = '{8'hFF, 8'h00, 8'h00, 16'd50};
      4'd1:    e = '{8'h00, 8'h00, 8'h00, 16'd50};
      4'd2:    e = '{8'h00, 8'hFF, 8'h00, 16'd50};
      4'd3:    e = '{8'h00, 8'h00, 8'h00, 16'd50};
      4'd4:    e = '{8'h00, 8'h00, 8'hFF, 16'd50};
      4'd5:    e = '{8'h00, 8'h00, 8'h00, 16'd50};
      4'd6:    e = '{8'hFF, 8'hFF, 8'hFF, 16'd100};
      4'd7:    e = '{8'h00, 8'h00, 8'h00, 16'd100};
      4'd8:    e = '{8'hFF, 8'h00, 8'hFF, 16'd50};
      4'd9:    e = '{8'hFF, 8'hFF, 8'h00, 16'd50};
      4'd10:   e = '{8'h00, 8'hFF, 8'hFF, 16'd50};
      4'd11:   e = '{8'h00, 8'h00, 8'h00, 16'd100};
      default: e = '{8'hFF, 8'h00, 8'h00, 16'd50};
    endcase
    return e;
  endfunction

endpackage

// ===== hdl/lps_if.sv =====
// ----------------------------------------------------------------------------
// lps_if
// Channel interfaces of the LED pattern sequencer: request items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface lps_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       host_connected;
  logic [7:0] command;
  logic [7:0] arg1;
  logic [7:0] arg2;
  logic [7:0] arg3;
  logic [7:0] arg4;
  logic [7:0] arg5;
  logic [7:0] arg6;

  modport source (
    output valid, func, host_connected, command, arg1, arg2, arg3, arg4, arg5, arg6,
    input  ready
  );
  modport sink (
    input  valid, func, host_connected, command, arg1, arg2, arg3, arg4, arg5, arg6,
    output ready
  );
endinterface

interface lps_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] duration;
  logic [7:0]  info_a;
  logic [7:0]  info_b;
  logic        info_c;

  modport source (
    output valid, action, red, green, blue, duration, info_a, info_b, info_c,
    input  ready
  );
  modport sink (
    input  valid, action, red, green, blue, duration, info_a, info_b, info_c,
    output ready
  );
endinterface

interface lps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/lps_table.sv =====
// ----------------------------------------------------------------------------
// lps_table
// Pattern table memory: one write port, one registered read port. Per-entry
// valid bits make unwritten entries read as the default pattern.
// ----------------------------------------------------------------------------
module lps_table
  import lps_pkg::*;
#(
  parameter int PATTERN_DEPTH = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rd_en,
  input  logic [$clog2(PATTERN_DEPTH)-1:0] rd_addr,
  input  logic                             wr_en,
  input  logic [$clog2(PATTERN_DEPTH)-1:0] wr_addr,
  input  entry_t                           wr_data,
  output entry_t                           rd_data
);

  entry_t                   mem [PATTERN_DEPTH];
  logic [PATTERN_DEPTH-1:0] written;
  entry_t                   rd_q;
  entry_t                   rd_def;
  logic                     rd_hit;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // registered read with default fallback
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_hit <= written[rd_addr];
      rd_def <= default_entry(DEF_IDX_W'(rd_addr));
    end
  end

  assign rd_data = rd_hit ? rd_q : rd_def;

endmodule

// ===== hdl/lps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lps_ctrl
// Accept stage: configuration registers, time keeping, watchdog, player
// state and command decode. Issues table accesses and result items.
// ----------------------------------------------------------------------------
module lps_ctrl
  import lps_pkg::*;
#(
  parameter int PATTERN_DEPTH = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  lps_req_if.sink                          req,
  lps_cfg_if.sink                          cfg,
  input  flow_t                            flow,
  output logic [7:0]                       duration_unit_ms,
  output logic                             tbl_rd_en,
  output logic [$clog2(PATTERN_DEPTH)-1:0] tbl_rd_addr,
  output logic                             tbl_wr_en,
  output logic [$clog2(PATTERN_DEPTH)-1:0] tbl_wr_addr,
  output entry_t                           tbl_wr_data,
  output logic                             item_push,
  output item_t                            item
);

  localparam int IDX_W = $clog2(PATTERN_DEPTH);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(PATTERN_DEPTH - 1);

  logic [15:0]      powerup_wait_ms;
  logic [7:0]       check_period_ms;
  logic [31:0]      now_ms,       now_ms_next;
  logic [31:0]      check_due,    check_due_next;
  logic [31:0]      step_due,     step_due_next;
  logic [31:0]      watchdog_due, watchdog_due_next;
  logic [15:0]      watchdog_time, watchdog_time_next;
  play_mode_t       play_mode,    play_mode_next;
  logic [IDX_W-1:0] play_position, play_position_next;

  logic             acc;
  logic             has_result;
  logic             rd_need;
  logic             wr_need;
  logic             black;
  logic [31:0]      now1;
  logic [15:0]      t23;
  logic [23:0]      wd_prod;
  logic [IDX_W-1:0] entry_idx;
  logic [IDX_W-1:0] play_start;

  assign acc       = req.valid && req.ready;
  assign req.ready = flow.ready;
  assign cfg.ready = 1'b1;

  assign now1     = now_ms + 32'd1;
  assign t23      = {req.arg2, req.arg3};
  assign wd_prod  = {8'd0, t23} * {16'd0, duration_unit_ms};
  assign entry_idx  = ({24'd0, req.arg6} < PATTERN_DEPTH) ? req.arg6[IDX_W-1:0] : '0;
  assign play_start = ({24'd0, req.arg2} < PATTERN_DEPTH) ? req.arg2[IDX_W-1:0] : LAST_POS;

  // item decode and next state
  always_comb begin
    now_ms_next        = now_ms;
    check_due_next     = check_due;
    step_due_next      = step_due;
    watchdog_due_next  = watchdog_due;
    watchdog_time_next = watchdog_time;
    play_mode_next     = play_mode;
    play_position_next = play_position;
    item        = '0;
    has_result  = 1'b0;
    rd_need     = 1'b0;
    tbl_rd_addr = play_position;
    wr_need     = 1'b0;
    black       = 1'b0;

    if (req.func == FUNC_TICK) begin
      now_ms_next = now1;
      // periodic power-up / host check
      if (is_after(now1, check_due)) begin
        check_due_next = check_due + {24'd0, check_period_ms};
        if (!req.host_connected) begin
          if (play_mode == PLAY_STOP && now1 > {16'd0, powerup_wait_ms}) begin
            play_mode_next     = PLAY_POWERUP;
            play_position_next = '0;
            step_due_next      = now1;
          end
        end else if (play_mode == PLAY_POWERUP) begin
          play_mode_next = PLAY_STOP;
          black          = 1'b1;
        end
      end
      // server-down watchdog expiry
      if (watchdog_time != 16'd0 && is_after(now1, watchdog_due)) begin
        watchdog_time_next = '0;
        play_mode_next     = PLAY_NORMAL;
        play_position_next = '0;
        step_due_next      = now1;
      end
      // pattern step
      if (play_mode_next != PLAY_STOP && !black && is_after(now1, step_due_next)) begin
        rd_need            = 1'b1;
        tbl_rd_addr        = play_position_next;
        play_position_next = (play_position_next == LAST_POS) ? '0
                             : play_position_next + IDX_W'(1);
        has_result         = 1'b1;
        item.step          = 1'b1;
        item.use_entry     = 1'b1;
        item.action        = ACT_FADE;
      end
    end else begin
      unique case (req.command)
        CMD_FADE: begin
          play_mode_next = PLAY_STOP;
          has_result     = 1'b1;
          item.action    = ACT_FADE;
          item.red       = req.arg1;
          item.green     = req.arg2;
          item.blue      = req.arg3;
          item.duration  = {req.arg4, req.arg5};
        end
        CMD_SET_NOW: begin
          has_result  = 1'b1;
          item.action = ACT_SET_NOW;
          item.red    = req.arg1;
          item.green  = req.arg2;
          item.blue   = req.arg3;
        end
        CMD_PLAY: begin
          if (req.arg1 == 8'd0) begin
            play_mode_next = PLAY_STOP;
          end else if (req.arg1 == PLAY_FLAG_POWERUP) begin
            play_mode_next = PLAY_POWERUP;
          end else begin
            play_mode_next = PLAY_NORMAL;
          end
          play_position_next = play_start;
          step_due_next      = now_ms;
        end
        CMD_WRITE: begin
          wr_need = 1'b1;
        end
        CMD_READ: begin
          rd_need        = 1'b1;
          tbl_rd_addr    = entry_idx;
          has_result     = 1'b1;
          item.use_entry = 1'b1;
          item.action    = ACT_ENTRY;
        end
        CMD_WDOG: begin
          if (req.arg1 != 8'd0) begin
            watchdog_time_next = t23;
            watchdog_due_next  = now_ms + {8'd0, wd_prod};
          end else begin
            watchdog_time_next = '0;
          end
          if (req.arg4 == 8'd0) begin
            play_mode_next = PLAY_STOP;
            black          = 1'b1;
          end
        end
        CMD_VERSION: begin
          has_result  = 1'b1;
          item.action = ACT_VERSION;
          item.info_a = VERSION_CHAR;
          item.info_b = VERSION_CHAR;
        end
        CMD_TEST: begin
          has_result  = 1'b1;
          item.action = ACT_TEST;
          item.info_a = TEST_BYTE_A;
          item.info_b = TEST_BYTE_B;
          item.info_c = req.host_connected;
        end
        default: begin
        end
      endcase
    end

    // stop with black set-now reply
    if (black) begin
      has_result  = 1'b1;
      item        = '0;
      item.action = ACT_SET_NOW;
    end
  end

  // table and output-stage requests
  assign tbl_rd_en   = acc && rd_need;
  assign tbl_wr_en   = acc && wr_need;
  assign tbl_wr_addr = entry_idx;
  assign tbl_wr_data = '{req.arg1, req.arg2, req.arg3, {req.arg4, req.arg5}};
  assign item_push   = acc && has_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      powerup_wait_ms  <= POWERUP_WAIT_RST;
      duration_unit_ms <= DURATION_UNIT_RST;
      check_period_ms  <= CHECK_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_POWERUP_WAIT:  powerup_wait_ms  <= cfg.data;
        CFG_DURATION_UNIT: duration_unit_ms <= cfg.data[7:0];
        CFG_CHECK_PERIOD:  check_period_ms  <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // state registers; step deadline also advanced by the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms        <= '0;
      check_due     <= '0;
      step_due      <= '0;
      watchdog_due  <= '0;
      watchdog_time <= '0;
      play_mode     <= PLAY_STOP;
      play_position <= '0;
    end else if (acc) begin
      now_ms        <= now_ms_next;
      check_due     <= check_due_next;
      step_due      <= step_due_next;
      watchdog_due  <= watchdog_due_next;
      watchdog_time <= watchdog_time_next;
      play_mode     <= play_mode_next;
      play_position <= play_position_next;
    end else if (flow.step_en) begin
      step_due <= step_due + {8'd0, flow.step_amt};
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    play_position <= LAST_POS)
    else $error("play position out of table range");

  a_step_needs_play: assert property (@(posedge clk) disable iff (rst)
    item_push && item.step |=> play_mode != PLAY_STOP)
    else $error("pattern step issued while player stopped");

  a_one_table_op: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> !tbl_rd_en)
    else $error("table read and write from the same item");

endmodule

// ===== hdl/lps_out.sv =====
// ----------------------------------------------------------------------------
// lps_out
// Result stages: merges table read data into result items, advances the
// step deadline for pattern steps and holds the output register.
// ----------------------------------------------------------------------------
module lps_out
  import lps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_push,
  input  item_t      item,
  input  entry_t     tbl_data,
  input  logic [7:0] duration_unit_ms,
  output flow_t      flow,
  lps_rsp_if.source  rsp
);

  logic  b_valid;
  item_t b_item;
  logic  b_move;
  item_t b_res;
  logic  c_valid;
  item_t c_res;

  // merge table data into the waiting item
  always_comb begin
    b_res = b_item;
    if (b_item.use_entry) begin
      b_res.red      = tbl_data.red;
      b_res.green    = tbl_data.green;
      b_res.blue     = tbl_data.blue;
      b_res.duration = tbl_data.duration;
    end
  end

  assign b_move = b_valid && (!c_valid || rsp.ready);

  // hold off new items while a step deadline update is pending
  assign flow.ready    = (!b_valid || b_move) && !(b_valid && b_item.step);
  assign flow.step_en  = b_move && b_item.step;
  assign flow.step_amt = {8'd0, tbl_data.duration} * {16'd0, duration_unit_ms};

  // middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (item_push) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_push) begin
      b_item <= item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_move) begin
      c_valid <= 1'b1;
    end else if (rsp.ready) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_res <= b_res;
    end
  end

  assign rsp.valid    = c_valid;
  assign rsp.action   = c_res.action;
  assign rsp.red      = c_res.red;
  assign rsp.green    = c_res.green;
  assign rsp.blue     = c_res.blue;
  assign rsp.duration = c_res.duration;
  assign rsp.info_a   = c_res.info_a;
  assign rsp.info_b   = c_res.info_b;
  assign rsp.info_c   = c_res.info_c;

  // checks
  a_step_interlock: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_item.step |-> !item_push)
    else $error("item accepted during pending step update");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    item_push |-> !b_valid || b_move)
    else $error("middle stage overwritten");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    b_valid && c_valid && !rsp.ready |=> b_valid && c_valid)
    else $error("result dropped while output stalled");

endmodule

// ===== hdl/led_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// LED pattern sequencer: tick and host command items in, fade / set-colour
// requests and replies out, pattern table in a synchronous memory.
// ----------------------------------------------------------------------------
// A result is presented after its item has passed the accept stage, the
//   table read stage and the output register.
// Throughput: one item per cycle unless the output stalls; a tick's pattern
//   step holds off the next item while the deadline adds the entry's duration.
// Reset (synchronous): time and player state clear, registers return to
//   500/10/10, the table reads as the default pattern at once (no clear pass).
module led_pattern_sequencer_top
  import lps_pkg::*;
#(
  parameter int PATTERN_DEPTH = 12
) (
  input  logic      clk,
  input  logic      rst,
  lps_req_if.sink   req,
  lps_rsp_if.source rsp,
  lps_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(PATTERN_DEPTH);

  flow_t            flow;
  logic [7:0]       duration_unit_ms;
  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_addr;
  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  entry_t           tbl_rd_data;
  logic             item_push;
  item_t            item;

  lps_ctrl #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .cfg              (cfg),
    .flow             (flow),
    .duration_unit_ms (duration_unit_ms),
    .tbl_rd_en        (tbl_rd_en),
    .tbl_rd_addr      (tbl_rd_addr),
    .tbl_wr_en        (tbl_wr_en),
    .tbl_wr_addr      (tbl_wr_addr),
    .tbl_wr_data      (tbl_wr_data),
    .item_push        (item_push),
    .item             (item)
  );

  lps_table #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data)
  );

  lps_out u_out (
    .clk              (clk),
    .rst              (rst),
    .item_push        (item_push),
    .item             (item),
    .tbl_data         (tbl_rd_data),
    .duration_unit_ms (duration_unit_ms),
    .flow             (flow),
    .rsp              (rsp)
  );

endmodule

// ===== bench/tb_led_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_top
// Self-checking bench for the LED pattern sequencer. A model of the player
// (time, check cadence, watchdog, pattern table, play position) predicts the
// result of every accepted tick or command item, and each result leaving
// the block is compared field by field against the oldest prediction.
// Stimulus is a directed opening followed by random phases, one for each
// setting of the three registers, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_led_pattern_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  localparam int DEPTH  = 12;
  localparam int SETTLE = 4;       // cycles past the last result before idle
  localparam int LIMIT  = 400000;  // cycle budget for the whole run

  // one input item as seen on the request channel
  typedef struct packed {
    logic       func;
    logic       host;
    logic [7:0] command;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [7:0] arg3;
    logic [7:0] arg4;
    logic [7:0] arg5;
    logic [7:0] arg6;
  } lps_item_t;

  // one light request or reply as seen on the result channel
  typedef struct packed {
    action_t     action;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
    logic [7:0]  info_a;
    logic [7:0]  info_b;
    logic        info_c;
  } led_result_t;

  // --------------------------------------------------------------------------
  // Player model: predicts lights from items, checks lights from the block
  // --------------------------------------------------------------------------
  class light_predictor;
    logic [15:0] wait_ms;
    logic [7:0]  unit_ms;
    logic [7:0]  period_ms;
    logic [31:0] now_ms;
    logic [31:0] check_at;
    logic [31:0] step_at;
    logic [31:0] wdog_at;
    logic [15:0] wdog_len;
    play_mode_t  mode;
    logic [3:0]  pos;
    entry_t      pattern [DEPTH];
    led_result_t due_lights [$];
    int          errors;
    int          items_in;
    int          lights_out;

    function new();
      entry_t boot [12];
      boot = '{'{8'hFF, 8'h00, 8'h00, 16'd50},  '{8'h00, 8'h00, 8'h00, 16'd50},
               '{8'h00, 8'hFF, 8'h00, 16'd50},  '{8'h00, 8'h00, 8'h00, 16'd50},
               '{8'h00, 8'h00, 8'hFF, 16'd50},  '{8'h00, 8'h00, 8'h00, 16'd50},
               '{8'hFF, 8'hFF, 8'hFF, 16'd100}, '{8'h00, 8'h00, 8'h00, 16'd100},
               '{8'hFF, 8'h00, 8'hFF, 16'd50},  '{8'hFF, 8'hFF, 8'h00, 16'd50},
               '{8'h00, 8'hFF, 8'hFF, 16'd50},  '{8'h00, 8'h00, 8'h00, 16'd100}};
      wait_ms   = POWERUP_WAIT_RST;
      unit_ms   = DURATION_UNIT_RST;
      period_ms = CHECK_PERIOD_RST;
      now_ms    = '0;
      check_at  = '0;
      step_at   = '0;
      wdog_at   = '0;
      wdog_len  = '0;
      mode      = PLAY_STOP;
      pos       = '0;
      for (int i = 0; i < DEPTH; i++) pattern[i] = boot[i % 12];
      errors     = 0;
      items_in   = 0;
      lights_out = 0;
    endfunction

    // a after b, with 32-bit wrap
    function bit later(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && (d < 32'h8000_0000);
    endfunction

    function void push(action_t act, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                       logic [15:0] dur, logic [7:0] ia, logic [7:0] ib, logic ic);
      led_result_t l;
      l = '{act, r, g, b, dur, ia, ib, ic};
      due_lights.push_back(l);
    endfunction

    function void start_play(play_mode_t m);
      mode    = m;
      pos     = '0;
      step_at = now_ms;
    endfunction

    function void write_reg(cfg_addr_t a, logic [15:0] d);
      case (a)
        CFG_POWERUP_WAIT:  wait_ms   = d;
        CFG_DURATION_UNIT: unit_ms   = d[7:0];
        CFG_CHECK_PERIOD:  period_ms = d[7:0];
        default: ;
      endcase
    endfunction

    // one millisecond: periodic host check, watchdog, pattern step
    function void tick(logic host);
      bit     told;
      entry_t e;
      told = 0;
      now_ms++;
      if (later(now_ms, check_at)) begin
        check_at += 32'(period_ms);
        if (!host) begin
          if (mode == PLAY_STOP && now_ms > 32'(wait_ms)) start_play(PLAY_POWERUP);
        end else if (mode == PLAY_POWERUP) begin
          mode = PLAY_STOP;
          push(ACT_SET_NOW, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 1'b0);
          told = 1;
        end
      end
      if (wdog_len != 16'd0 && later(now_ms, wdog_at)) begin
        wdog_len = '0;
        start_play(PLAY_NORMAL);
      end
      if (mode != PLAY_STOP && !told && later(now_ms, step_at)) begin
        e = pattern[pos];
        push(ACT_FADE, e.red, e.green, e.blue, e.duration, 8'd0, 8'd0, 1'b0);
        pos = (pos == 4'(DEPTH - 1)) ? 4'd0 : pos + 4'd1;
        step_at += 32'(e.duration) * 32'(unit_ms);
      end
    endfunction

    // note an accepted item and predict its light, if any
    function void note_item(lps_item_t it);
      int          idx;
      logic [15:0] t45;
      logic [15:0] t23;
      items_in++;
      idx = (it.arg6 < DEPTH) ? int'(it.arg6) : 0;
      t45 = {it.arg4, it.arg5};
      t23 = {it.arg2, it.arg3};
      if (it.func == FUNC_TICK) begin
        tick(it.host);
        return;
      end
      case (it.command)
        CMD_FADE: begin
          mode = PLAY_STOP;
          push(ACT_FADE, it.arg1, it.arg2, it.arg3, t45, 8'd0, 8'd0, 1'b0);
        end
        CMD_SET_NOW: push(ACT_SET_NOW, it.arg1, it.arg2, it.arg3, 16'd0, 8'd0, 8'd0, 1'b0);
        CMD_PLAY: begin
          if (it.arg1 == 8'd0) mode = PLAY_STOP;
          else if (it.arg1 == PLAY_FLAG_POWERUP) mode = PLAY_POWERUP;
          else mode = PLAY_NORMAL;
          pos     = (it.arg2 < DEPTH) ? it.arg2[3:0] : 4'(DEPTH - 1);
          step_at = now_ms;
        end
        CMD_WRITE: pattern[idx] = '{it.arg1, it.arg2, it.arg3, t45};
        CMD_READ: push(ACT_ENTRY, pattern[idx].red, pattern[idx].green, pattern[idx].blue,
                       pattern[idx].duration, 8'd0, 8'd0, 1'b0);
        CMD_WDOG: begin
          if (it.arg1 != 8'd0) begin
            wdog_len = t23;
            wdog_at  = now_ms + 32'(t23) * 32'(unit_ms);
          end else begin
            wdog_len = '0;
          end
          if (it.arg4 == 8'd0) begin
            mode = PLAY_STOP;
            push(ACT_SET_NOW, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 1'b0);
          end
        end
        CMD_VERSION: push(ACT_VERSION, 8'd0, 8'd0, 8'd0, 16'd0, VERSION_CHAR, VERSION_CHAR, 1'b0);
        CMD_TEST: push(ACT_TEST, 8'd0, 8'd0, 8'd0, 16'd0, TEST_BYTE_A, TEST_BYTE_B, it.host);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("light %0d %s: got %0h, want %0h", lights_out, name, got, want));
    endtask

    task check_light(led_result_t got);
      led_result_t want;
      lights_out++;
      if (due_lights.size() == 0) begin
        report($sformatf("light %0d (action %0d) with nothing due", lights_out, got.action));
        return;
      end
      want = due_lights.pop_front();
      field("action", 16'(got.action), 16'(want.action));
      field("red", 16'(got.red), 16'(want.red));
      field("green", 16'(got.green), 16'(want.green));
      field("blue", 16'(got.blue), 16'(want.blue));
      field("duration", got.duration, want.duration);
      field("info_a", 16'(got.info_a), 16'(want.info_a));
      field("info_b", 16'(got.info_b), 16'(want.info_b));
      field("info_c", 16'(got.info_c), 16'(want.info_c));
    endtask

    task leftovers();
      if (due_lights.size() != 0)
        report($sformatf("%0d lights never came out", due_lights.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  logic host_now;

  always #4 clk = ~clk;

  lps_req_if req ();
  lps_rsp_if rsp ();
  lps_cfg_if cfg ();

  led_pattern_sequencer_top #(.PATTERN_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  light_predictor model = new();

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_led_pattern_sequencer_top: FAIL");
      $finish;
    end
  end

  // monitor: register writes, accepted items, accepted lights
  always @(posedge clk) begin : watch
    lps_item_t   seen;
    led_result_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) model.write_reg(cfg_addr_t'(cfg.addr), cfg.data);
      if (req.valid && req.ready) begin
        seen = '{req.func, req.host_connected, req.command, req.arg1, req.arg2,
                 req.arg3, req.arg4, req.arg5, req.arg6};
        model.note_item(seen);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{action_t'(rsp.action), rsp.red, rsp.green, rsp.blue, rsp.duration,
                rsp.info_a, rsp.info_b, rsp.info_c};
        model.check_light(got);
      end
    end
  end

  // receiver: changing stall styles plus two long hold-offs
  initial begin : receiver
    int hold;
    int style;
    int holds_done;
    int rx_cycle;
    rsp.ready  = 1'b0;
    hold       = 0;
    style      = 0;
    holds_done = 0;
    rx_cycle   = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 300 == 0) style = $urandom_range(0, 3);
      if (hold == 0 && holds_done < 2 &&
          model.items_in >= ((holds_done == 0) ? 400 : 1000)) begin
        hold = 150;
        holds_done++;
      end
      if (hold > 0) begin
        rsp.ready = 1'b0;
        hold--;
      end else begin
        case (style)
          0:       rsp.ready = 1'b1;
          1:       rsp.ready = ($urandom_range(0, 3) != 0);
          2:       rsp.ready = ((rx_cycle % 7) >= 3);
          default: rsp.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_item(lps_item_t it);
    @(negedge clk);
    req.valid          = 1'b1;
    req.func           = it.func;
    req.host_connected = it.host;
    req.command        = it.command;
    req.arg1           = it.arg1;
    req.arg2           = it.arg2;
    req.arg3           = it.arg3;
    req.arg4           = it.arg4;
    req.arg5           = it.arg5;
    req.arg6           = it.arg6;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic req_idle(int n);
    repeat (n) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
  endtask

  // stop sending and wait until every predicted light has come out
  task automatic drain();
    req_idle(1);
    while (model.due_lights.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_addr_t a, logic [15:0] d);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.addr  = a;
    cfg.data  = d;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_config(logic [15:0] wait_val, logic [7:0] unit, logic [7:0] period);
    drain();
    write_reg(CFG_POWERUP_WAIT, wait_val);
    write_reg(CFG_DURATION_UNIT, {8'd0, unit});
    write_reg(CFG_CHECK_PERIOD, {8'd0, period});
  endtask

  function automatic lps_item_t mk(logic f, logic h, logic [7:0] c, logic [7:0] a1,
                                   logic [7:0] a2, logic [7:0] a3, logic [7:0] a4,
                                   logic [7:0] a5, logic [7:0] a6);
    lps_item_t it;
    it = '{f, h, c, a1, a2, a3, a4, a5, a6};
    return it;
  endfunction

  // mostly ticks, commands with arguments shaped toward useful values
  function automatic lps_item_t random_item(logic host);
    lps_item_t it;
    int        pick;
    it = mk(FUNC_TICK, host, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < 62) return it;
    it.func = FUNC_CMD;
    pick    = $urandom_range(0, 99);
    if (pick < 5) begin
      it.command = CMD_FADE;
    end else if (pick < 12) begin
      it.command = CMD_SET_NOW;
    end else if (pick < 32) begin
      it.command = CMD_PLAY;
      case ($urandom_range(0, 3))
        0:       it.arg1 = 8'd0;
        1:       it.arg1 = PLAY_FLAG_POWERUP;
        2:       it.arg1 = 8'd1;
        default: ;
      endcase
      if ($urandom_range(0, 4) != 0) it.arg2 = 8'($urandom_range(0, DEPTH - 1));
    end else if (pick < 52) begin
      it.command = CMD_WRITE;
      if ($urandom_range(0, 6) != 0) it.arg6 = 8'($urandom_range(0, DEPTH - 1));
      if ($urandom_range(0, 4) != 0) {it.arg4, it.arg5} = 16'($urandom_range(0, 30));
    end else if (pick < 67) begin
      it.command = CMD_READ;
      if ($urandom_range(0, 6) != 0) it.arg6 = 8'($urandom_range(0, DEPTH - 1));
    end else if (pick < 80) begin
      it.command = CMD_WDOG;
      if ($urandom_range(0, 3) == 0) it.arg1 = 8'd0;
      if ($urandom_range(0, 4) != 0) {it.arg2, it.arg3} = 16'($urandom_range(0, 40));
      if ($urandom_range(0, 2) == 0) it.arg4 = 8'd0;
    end else if (pick < 87) begin
      it.command = CMD_VERSION;
    end else if (pick < 94) begin
      it.command = CMD_TEST;
    end
    return it;
  endfunction

  // bursts of items with random gaps, host link flipping now and then
  task automatic run_random(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) req_idle($urandom_range(1, 8));
      end
      if ($urandom_range(0, 39) == 0) host_now = !host_now;
      send_item(random_item(host_now));
      burst--;
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.func           = FUNC_TICK;
    req.host_connected = 1'b0;
    req.command        = 8'd0;
    req.arg1           = 8'd0;
    req.arg2           = 8'd0;
    req.arg3           = 8'd0;
    req.arg4           = 8'd0;
    req.arg5           = 8'd0;
    req.arg6           = 8'd0;
    cfg.valid          = 1'b0;
    cfg.addr           = CFG_POWERUP_WAIT;
    cfg.data           = 16'd0;
    host_now           = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: replies, table reads and writes, index limits, play and watchdog
    send_item(mk(FUNC_CMD, 1'b1, CMD_TEST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_TEST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(FUNC_CMD, 1'b0, CMD_VERSION, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b1, CMD_SET_NOW, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_FADE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd11));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd12));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_item(mk(FUNC_CMD, 1'b0, CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd5));
    // out-of-range index lands on entry zero
    send_item(mk(FUNC_CMD, 1'b0, CMD_WRITE, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'd200));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd5));
    send_item(mk(FUNC_CMD, 1'b0, CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0));
    send_item(mk(FUNC_CMD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // play from a position past the end: clamps to the last entry
    send_item(mk(FUNC_CMD, 1'b0, CMD_PLAY, 8'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_PLAY, PLAY_FLAG_POWERUP, 8'd3, 8'h00, 8'h00, 8'h00,
                 8'h00));
    send_item(mk(FUNC_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(FUNC_CMD, 1'b0, CMD_PLAY, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    // watchdog: arm keeping state, disarm with stop, arm with stop
    send_item(mk(FUNC_CMD, 1'b0, CMD_WDOG, 8'd1, 8'h00, 8'h01, 8'd1, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_WDOG, 8'd0, 8'h00, 8'h05, 8'd0, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b0, CMD_WDOG, 8'hFF, 8'h00, 8'h02, 8'd0, 8'h00, 8'h00));
    send_item(mk(FUNC_CMD, 1'b1, CMD_FADE, 8'h10, 8'h20, 8'h30, 8'h00, 8'h00, 8'h00));
    run_random(150);

    // register settings, extremes included
    host_now = 1'b0;
    set_config(16'd0, 8'd1, 8'd1);
    run_random(175);
    set_config(16'd65535, 8'd255, 8'd255);
    run_random(175);
    host_now = 1'b0;
    set_config(16'd20, 8'd2, 8'd5);
    run_random(175);
    set_config(16'd300, 8'd1, 8'd3);
    run_random(175);
    set_config(16'($urandom_range(0, 1500)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 255)));
    run_random(175);
    host_now = 1'b0;
    set_config(16'd0, 8'd255, 8'd1);
    run_random(175);

    drain();
    repeat (10) @(posedge clk);
    model.leftovers();
    if (model.errors == 0) begin
      $display("tb_led_pattern_sequencer_top: PASS");
    end else begin
      $display("tb_led_pattern_sequencer_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== led_pattern_sequencer_top.f =====
hdl/lps_pkg.sv
hdl/lps_if.sv
hdl/lps_table.sv
hdl/lps_ctrl.sv
hdl/lps_out.sv
hdl/led_pattern_sequencer_top.sv
bench/tb_led_pattern_sequencer_top.sv
